// ===== hw/rtl/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int DEF_REGION_UNITS = 4096;
  localparam int DEF_UNIT_BYTES   = 12;

  localparam logic [15:0] RESET_REGION_BYTES = 16'd49152;

  // register index taken from paddr[2]
  localparam logic REG_REGION_BYTES = 1'b0;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOMEM  = 2'd1,
    STAT_ZERO   = 2'd2,
    STAT_RANGE  = 2'd3
  } status_t;

  // per-field write enables of one header
  typedef struct packed {
    logic prev;
    logic next;
    logic size;
  } hdr_we_t;

  typedef enum logic [5:0] {
    S_FMT_A,
    S_FMT_B,
    S_IDLE,
    S_DECODE,
    S_DISPATCH,
    S_A_CHK,
    S_A_HDR,
    S_A_WHOLE,
    S_A_SPLIT,
    S_A_USE1,
    S_A_USE2,
    S_Q_RD,
    S_F_RD,
    S_F_UNLINK,
    S_F_HEAD,
    S_F_WCHK,
    S_F_WHDR,
    S_F_IA0,
    S_F_IA1,
    S_F_IA2,
    S_F_IA3,
    S_F_IB0,
    S_F_IB1,
    S_F_IB2,
    S_F_IB3,
    S_M_RD,
    S_M_SEL,
    S_M_CHK,
    S_M_B,
    S_M_N,
    S_M_N2,
    S_M_N3,
    S_M_END,
    S_FINISH
  } state_t;

endpackage

// ===== hw/rtl/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list allocator with coalescing over one region of units.
// ----------------------------------------------------------------------------
// One command is in work at a time. The time from taking the command beat
// until the sequencer is idle again grows for an allocate with each free
// block it walks past, and for a free with each free block walked and each
// merge. A free into an empty free list skips the walk and the merges, and a
// free whose block has a free lower neighbor that it does not join also
// tries a merge from the block itself. Commands are paced by the single
// header memory, whose read data is registered, and stepped by one sequencer.
// Reset and each region_bytes write format the region through the states
// S_FMT_A and S_FMT_B; the header store has no clearing pass. A finished
// result sits in the output register while the next command is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
  parameter int REGION_UNITS = ffha_pkg::DEF_REGION_UNITS,
  parameter int UNIT_BYTES   = ffha_pkg::DEF_UNIT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_block_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_offset,
  output logic [15:0] out_block_bytes,
  output logic [15:0] out_free_bytes,
  output logic [15:0] out_used_bytes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffha_pkg::*;

  localparam int LW = $clog2(REGION_UNITS + 1);
  localparam int GW = LW + 1;
  localparam int unsigned CAP = REGION_UNITS * UNIT_BYTES;
  localparam logic [LW-1:0] NONE = LW'(REGION_UNITS);
  localparam logic [GW-1:0] WALK_LIMIT = GW'(REGION_UNITS + 1);
  localparam logic [15:0] UB16 = 16'(UNIT_BYTES);

  function automatic logic link_ok(input logic [LW-1:0] u);
    return u < NONE;
  endfunction

  state_t state_r, state_nxt;
  logic [15:0] region_r, region_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [1:0]  cmd_r, cmd_nxt;
  logic [15:0] req_r, req_nxt;
  logic [15:0] off_r, off_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] aux_r, aux_nxt;
  logic [LW-1:0] aux2_r, aux2_nxt;
  logic [LW-1:0] hb_r, hb_nxt;
  logic [15:0] need_r, need_nxt;
  logic [LW-1:0] bsz_r, bsz_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic        first_r, first_nxt;
  logic        merged_r, merged_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic [15:0] payload_r, payload_nxt;
  status_t     status_r, status_nxt;
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] used_head_r, used_head_nxt;
  logic [15:0] free_cnt_r, free_cnt_nxt;
  logic [15:0] used_cnt_r, used_cnt_nxt;
  logic [LW-1:0] units_r, units_nxt;
  logic [15:0] usable_r, usable_nxt;

  logic [1:0]  out_status_r, out_status_nxt;
  logic [15:0] out_payload_r, out_payload_nxt;
  logic [15:0] out_bytes_r, out_bytes_nxt;
  logic [15:0] out_free_r, out_free_nxt;
  logic [15:0] out_used_r, out_used_nxt;

  // header memory port
  logic [LW-1:0] rd_link;
  hdr_we_t       we;
  logic [LW-1:0] wr_link, wr_prev, wr_next, wr_size;
  logic [LW-1:0] rd_prev, rd_next, rd_size;

  logic [15:0] div_x, div_q;

  logic        cfg_wr, cfg_hit;
  logic [15:0] capped;
  logic [31:0] sz32, need32;
  logic        fit, whole, guard_ok, range_bad, adj, load_out;

  ffha_hdr_ram #(
    .REGION_UNITS (REGION_UNITS),
    .LINK_W       (LW)
  ) u_ram (
    .clk     (clk),
    .rd_link (rd_link),
    .we      (we),
    .wr_link (wr_link),
    .wr_prev (wr_prev),
    .wr_next (wr_next),
    .wr_size (wr_size),
    .rd_prev (rd_prev),
    .rd_next (rd_next),
    .rd_size (rd_size)
  );

  ffha_div #(
    .UNIT_BYTES (UNIT_BYTES)
  ) u_div (
    .clk (clk),
    .x   (div_x),
    .q   (div_q)
  );

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = cfg_wr && (paddr[2] == REG_REGION_BYTES);
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_REGION_BYTES) ? {16'h0000, region_r} : 32'h0;

  assign capped    = (32'(region_r) > CAP) ? 16'(CAP) : region_r;
  assign sz32      = 32'(rd_size);
  assign need32    = 32'(need_r);
  assign fit       = sz32 >= need32;
  assign whole     = (sz32 - need32) <= 32'd1;
  assign guard_ok  = guard_r < WALK_LIMIT;
  assign range_bad = (div_q == 16'h0000) || ((32'(div_q) - 32'd1) >= 32'(units_r));
  assign adj       = link_ok(rd_next) &&
                     (32'(rd_next) == 32'(cur_r) + 32'(rd_size) + 32'd1);
  assign load_out  = !out_valid_r || out_ready;

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_payload_offset = out_payload_r;
  assign out_block_bytes    = out_bytes_r;
  assign out_free_bytes     = out_free_r;
  assign out_used_bytes     = out_used_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (cfg_hit) begin
      state_nxt = S_FMT_A;
    end else begin
      unique case (state_r)
        S_FMT_A:    state_nxt = S_FMT_B;
        S_FMT_B:    state_nxt = S_IDLE;
        S_IDLE:     if (in_valid) state_nxt = S_DECODE;
        S_DECODE:   state_nxt = S_DISPATCH;
        S_DISPATCH: begin
          unique case (cmd_r)
            CMD_ALLOC: state_nxt = (req_r == 16'h0000) ? S_FINISH : S_A_CHK;
            CMD_FREE:  state_nxt = range_bad ? S_FINISH : S_F_RD;
            CMD_QUERY: state_nxt = range_bad ? S_FINISH : S_Q_RD;
            default:   state_nxt = S_FINISH;
          endcase
        end
        S_A_CHK:    state_nxt = (guard_ok && link_ok(cur_r)) ? S_A_HDR : S_FINISH;
        S_A_HDR: begin
          priority if (!fit) state_nxt = S_A_CHK;
          else if (whole)    state_nxt = S_A_WHOLE;
          else               state_nxt = S_A_SPLIT;
        end
        S_A_WHOLE:  state_nxt = S_A_USE1;
        S_A_SPLIT:  state_nxt = S_A_USE1;
        S_A_USE1:   state_nxt = S_A_USE2;
        S_A_USE2:   state_nxt = S_FINISH;
        S_Q_RD:     state_nxt = S_FINISH;
        S_F_RD:     state_nxt = S_F_UNLINK;
        S_F_UNLINK: state_nxt = S_F_HEAD;
        S_F_HEAD:   state_nxt = link_ok(free_head_r) ? S_F_WCHK : S_FINISH;
        S_F_WCHK: begin
          priority if (guard_ok && (cur_r < hb_r)) state_nxt = S_F_WHDR;
          else if (cur_r >= hb_r)                 state_nxt = S_F_IA0;
          else                                    state_nxt = S_F_IB0;
        end
        S_F_WHDR:   state_nxt = link_ok(rd_next) ? S_F_WCHK : S_F_IB0;
        S_F_IA0:    state_nxt = S_F_IA1;
        S_F_IA1:    state_nxt = S_F_IA2;
        S_F_IA2:    state_nxt = S_F_IA3;
        S_F_IA3:    state_nxt = S_M_RD;
        S_F_IB0:    state_nxt = S_F_IB1;
        S_F_IB1:    state_nxt = S_F_IB2;
        S_F_IB2:    state_nxt = S_F_IB3;
        S_F_IB3:    state_nxt = S_M_RD;
        S_M_RD:     state_nxt = S_M_SEL;
        S_M_SEL:    state_nxt = S_M_CHK;
        S_M_CHK:    state_nxt = guard_ok ? S_M_B : S_M_END;
        S_M_B:      state_nxt = adj ? S_M_N : S_M_END;
        S_M_N:      state_nxt = S_M_N2;
        S_M_N2:     state_nxt = S_M_N3;
        S_M_N3:     state_nxt = link_ok(aux2_r) ? S_M_CHK : S_M_END;
        S_M_END:    state_nxt = (first_r && !merged_r) ? S_M_CHK : S_FINISH;
        S_FINISH:   if (load_out) state_nxt = S_IDLE;
        default:    state_nxt = S_IDLE;
      endcase
    end
  end

  // datapath and memory control
  always_comb begin
    region_nxt    = cfg_hit ? pwdata[15:0] : region_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_nxt       = cmd_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    cur_nxt       = cur_r;
    aux_nxt       = aux_r;
    aux2_nxt      = aux2_r;
    hb_nxt        = hb_r;
    need_nxt      = need_r;
    bsz_nxt       = bsz_r;
    guard_nxt     = guard_r;
    first_nxt     = first_r;
    merged_nxt    = merged_r;
    bytes_nxt     = bytes_r;
    payload_nxt   = payload_r;
    status_nxt    = status_r;
    free_head_nxt = free_head_r;
    used_head_nxt = used_head_r;
    free_cnt_nxt  = free_cnt_r;
    used_cnt_nxt  = used_cnt_r;
    units_nxt     = units_r;
    usable_nxt    = usable_r;
    out_status_nxt  = out_status_r;
    out_payload_nxt = out_payload_r;
    out_bytes_nxt   = out_bytes_r;
    out_free_nxt    = out_free_r;
    out_used_nxt    = out_used_r;

    rd_link = cur_r;
    we      = '0;
    wr_link = cur_r;
    wr_prev = NONE;
    wr_next = NONE;
    wr_size = '0;
    div_x   = capped;

    unique case (state_r)
      S_FMT_A: begin
        usable_nxt = capped;
      end
      S_FMT_B: begin
        units_nxt     = LW'(div_q);
        used_head_nxt = NONE;
        used_cnt_nxt  = '0;
        if (div_q == 16'h0000) begin
          free_head_nxt = NONE;
          free_cnt_nxt  = '0;
        end else begin
          we            = '{prev: 1'b1, next: 1'b1, size: 1'b1};
          wr_link       = '0;
          wr_size       = LW'(div_q - 16'd1);
          free_head_nxt = '0;
          free_cnt_nxt  = usable_r - UB16;
        end
      end
      S_IDLE: begin
        cmd_nxt = in_cmd;
        req_nxt = in_request_bytes;
        off_nxt = in_block_offset;
      end
      S_DECODE: begin
        div_x = (cmd_r == CMD_ALLOC) ? req_r : off_r;
      end
      S_DISPATCH: begin
        bytes_nxt   = '0;
        payload_nxt = '0;
        status_nxt  = STAT_OK;
        hb_nxt      = LW'(div_q - 16'd1);
        rd_link     = LW'(div_q - 16'd1);
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (req_r == 16'h0000) begin
              status_nxt = STAT_ZERO;
            end else begin
              status_nxt = STAT_NOMEM;
              need_nxt   = div_q + 16'd1;
              cur_nxt    = free_head_r;
              guard_nxt  = '0;
            end
          end
          CMD_FREE, CMD_QUERY: begin
            if (range_bad) status_nxt = STAT_RANGE;
          end
          default: status_nxt = STAT_OK;
        endcase
      end
      S_A_CHK: begin
        rd_link = cur_r;
      end
      S_A_HDR: begin
        if (!fit) begin
          cur_nxt   = rd_next;
          guard_nxt = guard_r + GW'(1);
        end else if (whole) begin
          aux_nxt      = rd_prev;
          aux2_nxt     = rd_next;
          we.prev      = 1'b1;
          wr_link      = rd_next;
          wr_prev      = rd_prev;
          bytes_nxt    = 16'(sz32 * UNIT_BYTES);
          free_cnt_nxt = free_cnt_r - 16'(sz32 * UNIT_BYTES);
        end else begin
          we.size      = 1'b1;
          wr_link      = cur_r;
          wr_size      = LW'(sz32 - need32 - 32'd1);
          aux_nxt      = LW'(32'(cur_r) + sz32 - need32);
          bytes_nxt    = 16'(need32 * UNIT_BYTES);
          free_cnt_nxt = free_cnt_r - 16'(need32 * UNIT_BYTES) - UB16;
        end
      end
      S_A_WHOLE: begin
        if (link_ok(aux_r)) begin
          we.next = 1'b1;
          wr_link = aux_r;
          wr_next = aux2_r;
        end else begin
          free_head_nxt = aux2_r;
        end
      end
      S_A_SPLIT: begin
        we.size = 1'b1;
        wr_link = aux_r;
        wr_size = LW'(need_r);
        cur_nxt = aux_r;
      end
      S_A_USE1: begin
        we.prev = 1'b1;
        wr_link = used_head_r;
        wr_prev = cur_r;
      end
      S_A_USE2: begin
        we.prev       = 1'b1;
        we.next       = 1'b1;
        wr_link       = cur_r;
        wr_prev       = NONE;
        wr_next       = used_head_r;
        used_head_nxt = cur_r;
        used_cnt_nxt  = used_cnt_r + bytes_r;
        payload_nxt   = 16'((32'(cur_r) + 32'd1) * UNIT_BYTES);
        status_nxt    = STAT_OK;
      end
      S_Q_RD: begin
        bytes_nxt = 16'(sz32 * UNIT_BYTES);
      end
      S_F_RD: begin
        aux_nxt      = rd_prev;
        aux2_nxt     = rd_next;
        we.prev      = 1'b1;
        wr_link      = rd_next;
        wr_prev      = rd_prev;
        bytes_nxt    = 16'(sz32 * UNIT_BYTES);
        free_cnt_nxt = free_cnt_r + 16'(sz32 * UNIT_BYTES);
        used_cnt_nxt = used_cnt_r - 16'(sz32 * UNIT_BYTES);
      end
      S_F_UNLINK: begin
        if (link_ok(aux_r)) begin
          we.next = 1'b1;
          wr_link = aux_r;
          wr_next = aux2_r;
        end else begin
          used_head_nxt = aux2_r;
        end
      end
      S_F_HEAD: begin
        if (link_ok(free_head_r)) begin
          cur_nxt   = free_head_r;
          guard_nxt = '0;
        end else begin
          we.prev       = 1'b1;
          we.next       = 1'b1;
          wr_link       = hb_r;
          free_head_nxt = hb_r;
        end
      end
      S_F_WCHK: begin
        rd_link = cur_r;
      end
      S_F_WHDR: begin
        if (link_ok(rd_next)) begin
          cur_nxt   = rd_next;
          guard_nxt = guard_r + GW'(1);
        end
      end
      S_F_IA0, S_F_IB0: begin
        rd_link = cur_r;
      end
      S_F_IA1: begin
        // block goes in front of cur
        aux_nxt = rd_prev;
        we.prev = 1'b1;
        we.next = 1'b1;
        wr_link = hb_r;
        wr_prev = rd_prev;
        wr_next = cur_r;
      end
      S_F_IA2: begin
        if (link_ok(aux_r)) begin
          we.next = 1'b1;
          wr_link = aux_r;
          wr_next = hb_r;
        end else begin
          free_head_nxt = hb_r;
        end
      end
      S_F_IA3: begin
        we.prev = 1'b1;
        wr_link = cur_r;
        wr_prev = hb_r;
      end
      S_F_IB1: begin
        // block goes after cur
        aux_nxt = rd_next;
        we.prev = 1'b1;
        we.next = 1'b1;
        wr_link = hb_r;
        wr_prev = cur_r;
        wr_next = rd_next;
      end
      S_F_IB2: begin
        we.prev = 1'b1;
        wr_link = aux_r;
        wr_prev = hb_r;
      end
      S_F_IB3: begin
        we.next = 1'b1;
        wr_link = cur_r;
        wr_next = hb_r;
      end
      S_M_RD: begin
        rd_link = hb_r;
      end
      S_M_SEL: begin
        merged_nxt = 1'b0;
        guard_nxt  = '0;
        if (link_ok(rd_prev)) begin
          cur_nxt   = rd_prev;
          first_nxt = 1'b1;
        end else begin
          cur_nxt   = hb_r;
          first_nxt = 1'b0;
        end
      end
      S_M_CHK: begin
        rd_link = cur_r;
      end
      S_M_B: begin
        rd_link = rd_next;
        aux_nxt = rd_next;
        bsz_nxt = rd_size;
      end
      S_M_N: begin
        we.size      = 1'b1;
        wr_link      = cur_r;
        wr_size      = bsz_r + rd_size + LW'(1);
        free_cnt_nxt = free_cnt_r + UB16;
        merged_nxt   = 1'b1;
        aux2_nxt     = rd_next;
      end
      S_M_N2: begin
        we.prev = 1'b1;
        wr_link = aux2_r;
        wr_prev = cur_r;
      end
      S_M_N3: begin
        we.next = 1'b1;
        wr_link = cur_r;
        wr_next = link_ok(aux2_r) ? aux2_r : NONE;
        if (link_ok(aux2_r)) guard_nxt = guard_r + GW'(1);
      end
      S_M_END: begin
        if (first_r && !merged_r) begin
          cur_nxt    = hb_r;
          first_nxt  = 1'b0;
          merged_nxt = 1'b0;
          guard_nxt  = '0;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_payload_nxt = payload_r;
          out_bytes_nxt   = (status_r == STAT_OK) ? bytes_r : 16'h0000;
          out_free_nxt    = free_cnt_r;
          out_used_nxt    = used_cnt_r;
        end
      end
      default: begin
        rd_link = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FMT_A;
      region_r    <= RESET_REGION_BYTES;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      region_r    <= region_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    req_r       <= req_nxt;
    off_r       <= off_nxt;
    cur_r       <= cur_nxt;
    aux_r       <= aux_nxt;
    aux2_r      <= aux2_nxt;
    hb_r        <= hb_nxt;
    need_r      <= need_nxt;
    bsz_r       <= bsz_nxt;
    guard_r     <= guard_nxt;
    first_r     <= first_nxt;
    merged_r    <= merged_nxt;
    bytes_r     <= bytes_nxt;
    payload_r   <= payload_nxt;
    status_r    <= status_nxt;
    free_head_r <= free_head_nxt;
    used_head_r <= used_head_nxt;
    free_cnt_r  <= free_cnt_nxt;
    used_cnt_r  <= used_cnt_nxt;
    units_r     <= units_nxt;
    usable_r    <= usable_nxt;
    out_status_r  <= out_status_nxt;
    out_payload_r <= out_payload_nxt;
    out_bytes_r   <= out_bytes_nxt;
    out_free_r    <= out_free_nxt;
    out_used_r    <= out_used_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command is in work");

  a_cfg_formats: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (state_r == S_FMT_A))
    else $error("region write did not start a format");

  a_units_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (units_r <= NONE))
    else $error("active units exceed region");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && load_out && !cfg_hit) |=> (out_valid && state_r == S_IDLE))
    else $error("finished command did not post its beat");

endmodule

// ===== hw/rtl/ffha_hdr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_hdr_ram
// Header store: one read port with registered data, one write port with
// per-field enables. Links at or past the region size read as an empty
// header and drop their writes.
// ----------------------------------------------------------------------------
module ffha_hdr_ram #(
  parameter int REGION_UNITS = 4096,
  parameter int LINK_W       = 13
) (
  input  logic                 clk,
  input  logic [LINK_W-1:0]    rd_link,
  input  ffha_pkg::hdr_we_t    we,
  input  logic [LINK_W-1:0]    wr_link,
  input  logic [LINK_W-1:0]    wr_prev,
  input  logic [LINK_W-1:0]    wr_next,
  input  logic [LINK_W-1:0]    wr_size,
  output logic [LINK_W-1:0]    rd_prev,
  output logic [LINK_W-1:0]    rd_next,
  output logic [LINK_W-1:0]    rd_size
);
  import ffha_pkg::*;

  localparam int ADDR_W = $clog2(REGION_UNITS);
  localparam int HDR_W  = 3 * LINK_W;
  localparam logic [LINK_W-1:0] NONE = LINK_W'(REGION_UNITS);

  logic [HDR_W-1:0]  mem [REGION_UNITS];
  logic [HDR_W-1:0]  rd_q_r;
  logic              rd_hit_r;
  logic              rd_hit;
  logic              wr_hit;
  logic [ADDR_W-1:0] ra;
  logic [ADDR_W-1:0] wa;

  assign rd_hit = rd_link < NONE;
  assign wr_hit = wr_link < NONE;
  assign ra     = rd_link[ADDR_W-1:0];
  assign wa     = wr_link[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      if (we.prev) begin
        mem[wa][2*LINK_W +: LINK_W] <= wr_prev;
      end
      if (we.next) begin
        mem[wa][LINK_W +: LINK_W] <= wr_next;
      end
      if (we.size) begin
        mem[wa][0 +: LINK_W] <= wr_size;
      end
    end
    rd_q_r   <= mem[ra];
    rd_hit_r <= rd_hit;
  end

  assign rd_prev = rd_hit_r ? rd_q_r[2*LINK_W +: LINK_W] : NONE;
  assign rd_next = rd_hit_r ? rd_q_r[LINK_W +: LINK_W]   : NONE;
  assign rd_size = rd_hit_r ? rd_q_r[0 +: LINK_W]        : '0;

endmodule

// ===== hw/rtl/ffha_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_div
// Registered divide of a 16-bit value by the unit size, done as a multiply
// by a rounded-up reciprocal. Shared by format, allocate and address decode.
// ----------------------------------------------------------------------------
module ffha_div #(
  parameter int UNIT_BYTES = 12
) (
  input  logic        clk,
  input  logic [15:0] x,
  output logic [15:0] q
);
  import ffha_pkg::*;

  localparam int K      = 16 + $clog2(UNIT_BYTES);
  localparam int RW     = K + 1;
  localparam longint RECIP = ((64'd1 << K) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

  logic [16+RW-1:0] prod;
  logic [15:0]      q_r;

  assign prod = (16+RW)'(x) * (16+RW)'(RECIP_V);

  always_ff @(posedge clk) begin
    q_r <= prod[K +: 16];
  end

  assign q = q_r;

endmodule
